[hw/rtl/xn297_pkg.sv]
`timescale 1ns / 1ps

package xn297_pkg;

  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'hb5d2;
  localparam logic [7:0]  PREAMBLE_BYTE = 8'h55;
  localparam logic [6:0]  SCRAMBLE_LEN  = 7'd35;
  localparam logic [6:0]  XOROUT_LAST   = 7'd27;
  localparam logic [5:0]  COUNT_MAX     = 6'd63;

  localparam logic [2:0] LEN_MIN = 3'd3;
  localparam logic [2:0] LEN_MAX = 3'd5;
  localparam logic [2:0] LEN_PREAMBLE = 3'd4;

  // config register indexes
  localparam logic [1:0] REG_ADDRESS_LENGTH   = 2'd0;
  localparam logic [1:0] REG_TRANSMIT_ADDRESS = 2'd1;
  localparam logic [1:0] REG_SCRAMBLE_ENABLE  = 2'd2;
  localparam logic [1:0] REG_CRC_ENABLE       = 2'd3;

  // per-item sequence phases
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_PRE    = 3'd1;
  localparam logic [2:0] PH_ADDR   = 3'd2;
  localparam logic [2:0] PH_PAY    = 3'd3;
  localparam logic [2:0] PH_CRC_HI = 3'd4;
  localparam logic [2:0] PH_CRC_LO = 3'd5;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  addr_idx;
    logic [2:0]  len;
    logic [5:0]  count;
    logic [15:0] crc;
    logic [39:0] address;
    logic        scramble;
    logic        last;
    logic        overflow;
    logic [7:0]  payload;
  } byte_req_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] crc_next;
    logic [15:0] crc_final;
    logic        err;
  } byte_res_t;

  function automatic logic [7:0] whiten(input logic [5:0] idx);
    logic [7:0] w;
    case (idx)
      6'd0:  w = 8'he3; 6'd1:  w = 8'hb1; 6'd2:  w = 8'h4b; 6'd3:  w = 8'hea;
      6'd4:  w = 8'h85; 6'd5:  w = 8'hbc; 6'd6:  w = 8'he5; 6'd7:  w = 8'h66;
      6'd8:  w = 8'h0d; 6'd9:  w = 8'hae; 6'd10: w = 8'h8c; 6'd11: w = 8'h88;
      6'd12: w = 8'h12; 6'd13: w = 8'h69; 6'd14: w = 8'hee; 6'd15: w = 8'h1f;
      6'd16: w = 8'hc7; 6'd17: w = 8'h62; 6'd18: w = 8'h97; 6'd19: w = 8'hd5;
      6'd20: w = 8'h0b; 6'd21: w = 8'h79; 6'd22: w = 8'hca; 6'd23: w = 8'hcc;
      6'd24: w = 8'h1b; 6'd25: w = 8'h5d; 6'd26: w = 8'h19; 6'd27: w = 8'h10;
      6'd28: w = 8'h24; 6'd29: w = 8'hd3; 6'd30: w = 8'hdc; 6'd31: w = 8'h3f;
      6'd32: w = 8'h8e; 6'd33: w = 8'hc5; 6'd34: w = 8'h2f;
      default: w = 8'h00;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] xor_scr(input logic [4:0] idx);
    logic [15:0] x;
    case (idx)
      5'd0:  x = 16'h0000; 5'd1:  x = 16'h3448; 5'd2:  x = 16'h9BA7; 5'd3:  x = 16'h8BBB;
      5'd4:  x = 16'h85E1; 5'd5:  x = 16'h3E8C; 5'd6:  x = 16'h451E; 5'd7:  x = 16'h18E6;
      5'd8:  x = 16'h6B24; 5'd9:  x = 16'hE7AB; 5'd10: x = 16'h3828; 5'd11: x = 16'h814B;
      5'd12: x = 16'hD461; 5'd13: x = 16'hF494; 5'd14: x = 16'h2503; 5'd15: x = 16'h691D;
      5'd16: x = 16'hFE8B; 5'd17: x = 16'h9BA7; 5'd18: x = 16'h8B17; 5'd19: x = 16'h2920;
      5'd20: x = 16'h8B5F; 5'd21: x = 16'h61B1; 5'd22: x = 16'hD391; 5'd23: x = 16'h7401;
      5'd24: x = 16'h2138; 5'd25: x = 16'h129F; 5'd26: x = 16'hB3A0; 5'd27: x = 16'h2988;
      default: x = 16'h0000;
    endcase
    return x;
  endfunction

  function automatic logic [15:0] xor_plain(input logic [4:0] idx);
    logic [15:0] x;
    case (idx)
      5'd0:  x = 16'h0000; 5'd1:  x = 16'h3d5f; 5'd2:  x = 16'ha6f1; 5'd3:  x = 16'h3a23;
      5'd4:  x = 16'haa16; 5'd5:  x = 16'h1caf; 5'd6:  x = 16'h62b2; 5'd7:  x = 16'he0eb;
      5'd8:  x = 16'h0821; 5'd9:  x = 16'hbe07; 5'd10: x = 16'h5f1a; 5'd11: x = 16'haf15;
      5'd12: x = 16'h4f0a; 5'd13: x = 16'had24; 5'd14: x = 16'h5e48; 5'd15: x = 16'hed34;
      5'd16: x = 16'h068c; 5'd17: x = 16'hf2c9; 5'd18: x = 16'h1852; 5'd19: x = 16'hdf36;
      5'd20: x = 16'h129d; 5'd21: x = 16'hb17c; 5'd22: x = 16'hd5f5; 5'd23: x = 16'h70d7;
      5'd24: x = 16'hb798; 5'd25: x = 16'h5133; 5'd26: x = 16'h67db; 5'd27: x = 16'hd94e;
      default: x = 16'h0000;
    endcase
    return x;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = b[7 - k];
    end
    return r;
  endfunction

  // CRC-16, MSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/xn297_byte_gen.sv]
`timescale 1ns / 1ps

module xn297_byte_gen import xn297_pkg::*; (
  input  byte_req_t req,
  output byte_res_t res
);

  logic [2:0]  shift;
  logic [39:0] shifted;
  logic [7:0]  addr_b;
  logic [7:0]  pay_b;
  logic [6:0]  pos;
  logic [6:0]  xi;
  logic [15:0] pay_crc;
  logic        pos_over;
  logic        xi_over;
  logic [4:0]  xi_sel;

  always_comb begin
    shift   = req.len - 3'd1 - req.addr_idx;
    shifted = req.address >> {shift, 3'b000};
    addr_b  = shifted[7:0] ^ (req.scramble ? whiten({3'b000, req.addr_idx}) : 8'h00);

    pos      = {4'b0000, req.len} + {1'b0, req.count};
    pos_over = (pos >= SCRAMBLE_LEN);
    pay_b    = rev8(req.payload) ^ ((req.scramble && !pos_over) ? whiten(pos[5:0]) : 8'h00);
    pay_crc  = crc_byte(req.crc, pay_b);

    xi      = {4'b0000, req.len} - 7'd3 + {1'b0, req.count} + 7'd1;
    xi_over = (xi > XOROUT_LAST);
    xi_sel  = xi_over ? XOROUT_LAST[4:0] : xi[4:0];

    res = '0;
    case (req.phase)
      PH_PRE: begin
        res.data     = PREAMBLE_BYTE;
        res.crc_next = req.crc;
        res.err      = req.overflow;
      end
      PH_ADDR: begin
        res.data     = addr_b;
        res.crc_next = crc_byte(req.crc, addr_b);
        res.err      = req.overflow;
      end
      PH_PAY: begin
        res.data      = pay_b;
        res.crc_next  = pay_crc;
        res.crc_final = pay_crc ^ (req.scramble ? xor_scr(xi_sel) : xor_plain(xi_sel));
        res.err       = req.overflow | pos_over | (req.last & xi_over);
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

[hw/rtl/xn297_packet_encoder_top.sv]
`timescale 1ns / 1ps

// XN297-style frame encoder. Each accepted payload item yields one frame byte per
// cycle on the output unless out_ready stalls it: the first item of a packet is
// preceded by the header (an optional 0x55 byte when the address is shorter than
// 4, then the address bytes) and its payload byte; later items yield only their
// payload byte; with CRC on, the final item is followed by the two CRC bytes. A
// single byte sequencer emits into one output register; a new item is taken in
// the cycle its predecessor's last byte is emitted, so payload bytes stream at
// one per cycle while the output is not stalled.
// Configuration must only be written while the encoder is idle.

module xn297_packet_encoder_top import xn297_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  payload_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        frame_end,
  output logic        length_error
);

  logic [2:0]  address_length;
  logic [39:0] transmit_address;
  logic        scramble_enable;
  logic        crc_enable;

  logic [5:0]  payload_count;
  logic [15:0] crc_value;
  logic        overflow_seen;

  logic        item_valid;
  logic [7:0]  item_payload;
  logic        item_final;
  logic [2:0]  phase;
  logic [2:0]  addr_idx;
  logic [15:0] crc_final;
  logic        item_err;

  logic [2:0]  len;
  logic [2:0]  eph;
  logic        advance;
  logic        done;
  logic        load;
  byte_req_t   req;
  byte_res_t   res;

  always_comb begin
    if (address_length < LEN_MIN) begin
      len = LEN_MIN;
    end else if (address_length > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = address_length;
    end

    if (phase == PH_START) begin
      if (payload_count != 6'd0) begin
        eph = PH_PAY;
      end else if (len < LEN_PREAMBLE) begin
        eph = PH_PRE;
      end else begin
        eph = PH_ADDR;
      end
    end else begin
      eph = phase;
    end

    advance = item_valid && (!out_valid || out_ready);
    done    = advance && (((eph == PH_PAY) && !(item_final && crc_enable)) ||
                          (eph == PH_CRC_LO));
    in_ready = !item_valid || done;
    load     = in_valid && in_ready;

    req.phase    = eph;
    req.addr_idx = addr_idx;
    req.len      = len;
    req.count    = payload_count;
    req.crc      = crc_value;
    req.address  = transmit_address;
    req.scramble = scramble_enable;
    req.last     = item_final;
    req.overflow = overflow_seen;
    req.payload  = item_payload;
  end

  xn297_byte_gen u_byte_gen (
    .req (req),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      address_length   <= 3'd5;
      transmit_address <= 40'd0;
      scramble_enable  <= 1'b1;
      crc_enable       <= 1'b0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_ADDRESS_LENGTH:   address_length   <= cfg_data[2:0];
        REG_TRANSMIT_ADDRESS: transmit_address <= cfg_data;
        REG_SCRAMBLE_ENABLE:  scramble_enable  <= cfg_data[0];
        REG_CRC_ENABLE:       crc_enable       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_count <= 6'd0;
      crc_value     <= CRC_INIT;
      overflow_seen <= 1'b0;
      item_valid    <= 1'b0;
      phase         <= PH_START;
      addr_idx      <= 3'd0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (advance) begin
        case (eph)
          PH_PRE: begin
            frame_byte   <= res.data;
            frame_end    <= 1'b0;
            length_error <= res.err;
            phase        <= PH_ADDR;
          end
          PH_ADDR: begin
            frame_byte   <= res.data;
            frame_end    <= 1'b0;
            length_error <= res.err;
            crc_value    <= res.crc_next;
            if (addr_idx == len - 3'd1) begin
              phase <= PH_PAY;
            end else begin
              phase    <= PH_ADDR;
              addr_idx <= addr_idx + 3'd1;
            end
          end
          PH_PAY: begin
            frame_byte   <= res.data;
            frame_end    <= item_final && !crc_enable;
            length_error <= res.err;
            if (item_final) begin
              payload_count <= 6'd0;
              crc_value     <= CRC_INIT;
              overflow_seen <= 1'b0;
            end else begin
              payload_count <= (payload_count < COUNT_MAX) ? payload_count + 6'd1 : COUNT_MAX;
              crc_value     <= res.crc_next;
              overflow_seen <= res.err;
            end
            crc_final <= res.crc_final;
            item_err  <= res.err;
            if (item_final && crc_enable) begin
              phase <= PH_CRC_HI;
            end
          end
          PH_CRC_HI: begin
            frame_byte   <= crc_final[15:8];
            frame_end    <= 1'b0;
            length_error <= item_err;
            phase        <= PH_CRC_LO;
          end
          PH_CRC_LO: begin
            frame_byte   <= crc_final[7:0];
            frame_end    <= 1'b1;
            length_error <= item_err;
          end
          default: begin
            phase <= PH_START;
          end
        endcase
      end

      if (load) begin
        item_valid   <= 1'b1;
        item_payload <= payload_byte;
        item_final   <= final_byte;
        phase        <= PH_START;
        addr_idx     <= 3'd0;
      end else if (done) begin
        item_valid <= 1'b0;
      end
    end
  end

endmodule
